FILE: rtl/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

	typedef enum logic [2:0] {
		OP_INSERT      = 3'd0,
		OP_POP         = 3'd1,
		OP_LIST_ALL    = 3'd2,
		OP_LIST_SCORE  = 3'd3,
		OP_LIST_GRADE  = 3'd4,
		OP_CLEAR       = 3'd5
	} opcode_t;

	typedef enum logic [2:0] {
		STS_ENTRY    = 3'd0,
		STS_EMPTY    = 3'd1,
		STS_NONE     = 3'd2,
		STS_INSERTED = 3'd3,
		STS_FULL     = 3'd4,
		STS_CLEARED  = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INSERT,
		S_PLACE,
		S_POP,
		S_LIST,
		S_FLUSH
	} state_t;

	typedef struct packed {
		logic [15:0] tag;
		logic [7:0]  grade;
		logic [9:0]  score;
		logic [7:0]  key;
	} entry_t;

	typedef struct packed {
		status_t status;
		entry_t  ent;
		logic    last;
	} result_t;

	localparam int EntryWidth = $bits(entry_t);

endpackage

FILE: rtl/spq_ram.sv
`timescale 1ns / 1ps

module spq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/stable_priority_queue_with_filters.sv
`timescale 1ns / 1ps
// Clear, full and empty answers come in the cycle after start; unused opcodes
// are dropped with no answer and never raise busy. Insert into an empty queue answers in
// the cycle after start, else the tail walk shifts one entry per cycle through the
// single entry RAM until the new entry's place is found. Pop answers after its S_POP state.
// Lists stream only hits, at most one per cycle. Busy holds the next request off for as long as the answer takes.
// Reset (arst_n low) empties the queue at once; results strobe out_valid, never stalled.

module stable_priority_queue_with_filters #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  opcode,
	input  logic [15:0] tag,
	input  logic [7:0]  grade,
	input  logic [9:0]  score,
	input  logic [7:0]  priority_req,
	output logic        out_valid,
	output logic [2:0]  status,
	output logic [15:0] out_tag,
	output logic [7:0]  out_grade,
	output logic [9:0]  out_score,
	output logic [7:0]  out_priority,
	output logic        last
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	// Map a position in queue order onto a RAM slot: the queue lives in a
	// ring that starts at head, so pop only moves the head.
	function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] l);
		logic [CW:0] s;
		s = (CW+1)'(h) + (CW+1)'(l);
		if (s >= (CW+1)'(QUEUE_DEPTH)) begin
			s = s - (CW+1)'(QUEUE_DEPTH);
		end
		return s[AW-1:0];
	endfunction

	spq_pkg::state_t  state_q, state_d;
	logic [AW-1:0]    head_q, head_d;
	logic [CW-1:0]    count_q, count_d;
	logic [CW-1:0]    idx_q, idx_d;
	spq_pkg::opcode_t op_q;
	spq_pkg::entry_t  req_q;      // request fields held for the walk
	spq_pkg::entry_t  pend_q, pend_d;
	logic             pend_valid_q, pend_valid_d;
	spq_pkg::result_t res_q, res_d;
	logic             res_valid_q, res_valid_d;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr, ram_raddr;
	spq_pkg::entry_t  ram_wdata, rd_ent;
	logic [spq_pkg::EntryWidth-1:0] ram_rdata;

	spq_pkg::opcode_t op_in;
	spq_pkg::entry_t  new_in;
	logic             accept;
	logic             is_full, is_empty, at_tail;
	logic             shift, hit;

	assign op_in  = spq_pkg::opcode_t'(opcode);
	assign new_in = '{tag: tag, grade: grade, score: score, key: priority_req};
	assign accept = start && (state_q == spq_pkg::S_IDLE);
	assign busy   = (state_q != spq_pkg::S_IDLE);

	assign rd_ent   = spq_pkg::entry_t'(ram_rdata);
	assign is_full  = (count_q == CW'(QUEUE_DEPTH));
	assign is_empty = (count_q == '0);
	assign at_tail  = (idx_q == count_q - CW'(1));

	// Move the walked entry down while its key is strictly below the new key;
	// equal keys stay ahead, which keeps arrival order.
	assign shift = (rd_ent.key < req_q.key);

	always_comb begin
		unique case (op_q)
			spq_pkg::OP_LIST_SCORE: hit = (rd_ent.score >= req_q.score);
			spq_pkg::OP_LIST_GRADE: hit = (rd_ent.grade <= req_q.grade);
			default:                hit = 1'b1;
		endcase
	end

	spq_ram #(
		.WIDTH(spq_pkg::EntryWidth),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			spq_pkg::S_IDLE: begin
				if (start) begin
					unique case (op_in)
						spq_pkg::OP_INSERT: begin
							if (!is_full && !is_empty) state_d = spq_pkg::S_INSERT;
						end
						spq_pkg::OP_POP: begin
							if (!is_empty) state_d = spq_pkg::S_POP;
						end
						spq_pkg::OP_LIST_ALL, spq_pkg::OP_LIST_SCORE,
						spq_pkg::OP_LIST_GRADE: begin
							if (!is_empty) state_d = spq_pkg::S_LIST;
						end
						default: state_d = spq_pkg::S_IDLE;
					endcase
				end
			end
			spq_pkg::S_INSERT: begin
				if (!shift) state_d = spq_pkg::S_IDLE;
				else if (idx_q == '0) state_d = spq_pkg::S_PLACE;
			end
			spq_pkg::S_PLACE: state_d = spq_pkg::S_IDLE;
			spq_pkg::S_POP:   state_d = spq_pkg::S_IDLE;
			spq_pkg::S_LIST: begin
				if (at_tail) state_d = spq_pkg::S_FLUSH;
			end
			spq_pkg::S_FLUSH: state_d = spq_pkg::S_IDLE;
			default:          state_d = spq_pkg::S_IDLE;
		endcase
	end

	// Datapath, RAM access and result
	always_comb begin
		head_d       = head_q;
		count_d      = count_q;
		idx_d        = idx_q;
		pend_d       = pend_q;
		pend_valid_d = pend_valid_q;
		ram_we       = 1'b0;
		ram_waddr    = slot(head_q, '0);
		ram_wdata    = req_q;
		ram_raddr    = slot(head_q, '0);
		res_valid_d  = 1'b0;
		res_d        = '{status: spq_pkg::STS_ENTRY, ent: '0, last: 1'b1};

		unique case (state_q)
			spq_pkg::S_IDLE: begin
				if (start) begin
					unique case (op_in)
						spq_pkg::OP_INSERT: begin
							if (is_full) begin
								res_valid_d  = 1'b1;
								res_d.status = spq_pkg::STS_FULL;
							end else if (is_empty) begin
								// empty queue: place directly at head
								ram_we       = 1'b1;
								ram_wdata    = new_in;
								count_d      = count_q + CW'(1);
								res_valid_d  = 1'b1;
								res_d.status = spq_pkg::STS_INSERTED;
							end else begin
								// start the walk at the tail
								idx_d     = count_q - CW'(1);
								ram_raddr = slot(head_q, count_q - CW'(1));
							end
						end
						spq_pkg::OP_POP: begin
							if (is_empty) begin
								res_valid_d  = 1'b1;
								res_d.status = spq_pkg::STS_EMPTY;
							end
						end
						spq_pkg::OP_LIST_ALL, spq_pkg::OP_LIST_SCORE,
						spq_pkg::OP_LIST_GRADE: begin
							if (is_empty) begin
								res_valid_d  = 1'b1;
								res_d.status = spq_pkg::STS_EMPTY;
							end else begin
								idx_d        = '0;
								pend_valid_d = 1'b0;
							end
						end
						spq_pkg::OP_CLEAR: begin
							count_d      = '0;
							head_d       = '0;
							res_valid_d  = 1'b1;
							res_d.status = spq_pkg::STS_CLEARED;
						end
						default: begin
							// unused opcodes: drop silently
						end
					endcase
				end
			end
			spq_pkg::S_INSERT: begin
				ram_we    = 1'b1;
				ram_waddr = slot(head_q, idx_q + CW'(1));
				if (shift) begin
					ram_wdata = rd_ent;
					if (idx_q != '0) begin
						idx_d     = idx_q - CW'(1);
						ram_raddr = slot(head_q, idx_q - CW'(1));
					end
				end else begin
					ram_wdata    = req_q;
					count_d      = count_q + CW'(1);
					res_valid_d  = 1'b1;
					res_d.status = spq_pkg::STS_INSERTED;
				end
			end
			spq_pkg::S_PLACE: begin
				ram_we       = 1'b1;
				ram_wdata    = req_q;
				count_d      = count_q + CW'(1);
				res_valid_d  = 1'b1;
				res_d.status = spq_pkg::STS_INSERTED;
			end
			spq_pkg::S_POP: begin
				res_valid_d = 1'b1;
				res_d.ent   = rd_ent;
				head_d      = slot(head_q, CW'(1));
				count_d     = count_q - CW'(1);
			end
			spq_pkg::S_LIST: begin
				// hold one hit back so the final one can carry last
				if (hit) begin
					if (pend_valid_q) begin
						res_valid_d = 1'b1;
						res_d.ent   = pend_q;
						res_d.last  = 1'b0;
					end
					pend_d       = rd_ent;
					pend_valid_d = 1'b1;
				end
				if (!at_tail) begin
					idx_d     = idx_q + CW'(1);
					ram_raddr = slot(head_q, idx_q + CW'(1));
				end
			end
			spq_pkg::S_FLUSH: begin
				res_valid_d = 1'b1;
				if (pend_valid_q) begin
					res_d.ent = pend_q;
				end else begin
					res_d.status = spq_pkg::STS_NONE;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= spq_pkg::S_IDLE;
			head_q       <= '0;
			count_q      <= '0;
			idx_q        <= '0;
			pend_valid_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			head_q       <= head_d;
			count_q      <= count_d;
			idx_q        <= idx_d;
			pend_valid_q <= pend_valid_d;
			res_valid_q  <= res_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op_in;
			req_q <= new_in;
		end
		pend_q <= pend_d;
		res_q  <= res_d;
	end

	assign out_valid    = res_valid_q;
	assign status       = res_q.status;
	assign out_tag      = res_q.ent.tag;
	assign out_grade    = res_q.ent.grade;
	assign out_score    = res_q.ent.score;
	assign out_priority = res_q.ent.key;
	assign last         = res_q.last;

endmodule

FILE: rtl/spq_chk.sv
`timescale 1ns / 1ps

module spq_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [2:0]  opcode,
	input logic        out_valid,
	input logic [2:0]  status,
	input logic [15:0] out_tag,
	input logic [7:0]  out_grade,
	input logic [9:0]  out_score,
	input logic [7:0]  out_priority,
	input logic        last
);

	logic status_only;
	assign status_only = out_valid && (status != spq_pkg::STS_ENTRY);

	// a status answer always closes its request
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		status_only |-> last)
		else $error("status result without last");

	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		status_only |-> (out_tag == '0 && out_grade == '0 && out_score == '0
			&& out_priority == '0))
		else $error("status result with nonzero payload");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode == spq_pkg::OP_CLEAR) |=>
			(out_valid && last && status == spq_pkg::STS_CLEARED && !busy))
		else $error("clear not answered next cycle");

	a_unused_op: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (opcode > 3'(spq_pkg::OP_CLEAR))) |=> (!out_valid && !busy))
		else $error("unused opcode produced a result");

endmodule

bind stable_priority_queue_with_filters spq_chk u_spq_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.opcode      (opcode),
	.out_valid   (out_valid),
	.status      (status),
	.out_tag     (out_tag),
	.out_grade   (out_grade),
	.out_score   (out_score),
	.out_priority(out_priority),
	.last        (last)
);
